// ----- design/fri_fold_round_assert.svh -----
// Assertion macros used by the checker module of the fold block.
`ifndef FRI_FOLD_ROUND_ASSERT_SVH
`define FRI_FOLD_ROUND_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted.
`define FRI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define FRI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- design/fri_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package fri_pkg;

    localparam int VALUE_BITS = 30;
    localparam int ROUNDS     = 7;
    localparam int ROUND_BITS = 3;
    localparam int CFG_IDX_BITS = 3;

    // Multiplier operand scanned bit by bit: one bit wider than a field value
    localparam int OPER_BITS = VALUE_BITS + 1;

    localparam logic [VALUE_BITS-1:0] MIN_MODULUS = VALUE_BITS'(3);
    localparam logic [ROUND_BITS-1:0] LAST_ROUND  = ROUND_BITS'(ROUNDS - 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODULUS     = 3'd0,
        CFG_INV_TWO     = 3'd1,
        CFG_INV_COSET   = 3'd2,
        CFG_INV_ROOT    = 3'd3,
        CFG_CHALLENGE   = 3'd4,
        CFG_ROUND_INDEX = 3'd5
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT,
        S_SQUARE,
        S_COSET,
        S_TWO,
        S_RED_B,
        S_EVEN,
        S_DIFF,
        S_RED_DOM,
        S_ODD,
        S_CHAL,
        S_STEP,
        S_OUT
    } t_state;

    // Request to the modular multiplier: result is (x * m) mod q, m < q
    typedef struct packed {
        logic                  start;
        logic [OPER_BITS-1:0]  x;
        logic [VALUE_BITS-1:0] m;
    } t_mm_req;

endpackage
`default_nettype wire

// ----- design/fri_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface fri_in_if;
    import fri_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value_first;
    logic [VALUE_BITS-1:0] value_second;
    logic                  round_start;

    modport source (output valid, output value_first, output value_second,
                    output round_start, input ready);
    modport sink   (input valid, input value_first, input value_second,
                    input round_start, output ready);
endinterface
`default_nettype wire

// ----- design/fri_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface fri_out_if;
    import fri_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] folded;

    modport source (output valid, output folded, input ready);
    modport sink   (input valid, input folded, output ready);
endinterface
`default_nettype wire

// ----- design/fri_mulmod.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fri_mulmod (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fri_pkg::t_mm_req              i_req,
    input  wire logic [fri_pkg::VALUE_BITS-1:0] i_modulus,
    output logic                               o_done,
    output logic [fri_pkg::VALUE_BITS-1:0]     o_result
);
    import fri_pkg::*;

    localparam int SUM_BITS = VALUE_BITS + 2;
    localparam int CNT_BITS = $clog2(OPER_BITS + 1);

    logic [VALUE_BITS-1:0] r_acc;
    logic [OPER_BITS-1:0]  r_x;
    logic [VALUE_BITS-1:0] r_m;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [SUM_BITS-1:0]   sum;
    logic [SUM_BITS-1:0]   q1;
    logic [SUM_BITS-1:0]   q2;
    logic [VALUE_BITS-1:0] n_acc;

    // One bit of x per cycle, MSB first: acc = (2*acc + bit*m) mod q, below 3q
    always_comb begin
        q1  = {2'b00, i_modulus};
        q2  = {1'b0, i_modulus, 1'b0};
        sum = {1'b0, r_acc, 1'b0} + (r_x[OPER_BITS-1] ? {2'b00, r_m} : '0);
        priority if (sum >= q2) begin
            n_acc = VALUE_BITS'(sum - q2);
        end else if (sum >= q1) begin
            n_acc = VALUE_BITS'(sum - q1);
        end else begin
            n_acc = VALUE_BITS'(sum);
        end
    end

    // Track the pass and flag its last bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(OPER_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then shift and accumulate
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_x   <= i_req.x;
            r_m   <= i_req.m;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_x   <= {r_x[OPER_BITS-2:0], 1'b0};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule
`default_nettype wire

// ----- design/fri_fold_round.sv -----
// An input transaction is folded by a sequence of modular-multiplier passes into the output register.
// With round_start high add 2 + min(round_index, 6) passes for stride and coset setup.
// Each field operation is one pass of the bit-serial modular multiplier;
// an item takes 8 such passes, and a new item is taken only after the last one has left the sequencer.
// Input ready is high only while idle; a result may wait in the output register.
// Reset (synchronous, active low) loads register defaults and clears domain state.
`timescale 1ns / 1ps
`default_nettype none
module fri_fold_round (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [fri_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [fri_pkg::VALUE_BITS-1:0]   i_cfg_data,
    fri_in_if.sink                               i_in,
    fri_out_if.source                            o_out
);
    import fri_pkg::*;

    // Configuration registers
    logic [VALUE_BITS-1:0] r_modulus;
    logic [VALUE_BITS-1:0] r_inv_two;
    logic [VALUE_BITS-1:0] r_inv_coset;
    logic [VALUE_BITS-1:0] r_inv_root;
    logic [VALUE_BITS-1:0] r_challenge;
    logic [ROUND_BITS-1:0] r_round_index;

    // Sequencer and datapath
    t_state                r_state;
    t_state                n_state;
    logic                  r_issued;
    logic [ROUND_BITS-1:0] r_sq_cnt;
    logic [VALUE_BITS-1:0] r_a;
    logic [VALUE_BITS-1:0] r_b;
    logic [VALUE_BITS-1:0] r_stride;
    logic [VALUE_BITS-1:0] r_dom;
    logic [VALUE_BITS-1:0] r_half;
    logic [VALUE_BITS-1:0] r_even;
    logic [VALUE_BITS-1:0] r_tmp;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_folded;

    logic [VALUE_BITS-1:0] q;
    logic [ROUND_BITS-1:0] sq_limit;
    logic                  in_fire;
    logic                  load_out;
    t_mm_req               mm_req;
    logic                  mm_done;
    logic [VALUE_BITS-1:0] mm_res;
    logic [VALUE_BITS:0]   out_sum;
    logic [VALUE_BITS-1:0] n_folded;

    assign q        = (r_modulus < MIN_MODULUS) ? MIN_MODULUS : r_modulus;
    assign sq_limit = (r_round_index > LAST_ROUND) ? LAST_ROUND : r_round_index;
    assign in_fire  = i_in.valid && i_in.ready;

    // Write configuration registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus     <= VALUE_BITS'(3);
            r_inv_two     <= VALUE_BITS'(2);
            r_inv_coset   <= VALUE_BITS'(1);
            r_inv_root    <= VALUE_BITS'(1);
            r_challenge   <= '0;
            r_round_index <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_MODULUS:     r_modulus     <= i_cfg_data;
                CFG_INV_TWO:     r_inv_two     <= i_cfg_data;
                CFG_INV_COSET:   r_inv_coset   <= i_cfg_data;
                CFG_INV_ROOT:    r_inv_root    <= i_cfg_data;
                CFG_CHALLENGE:   r_challenge   <= i_cfg_data;
                CFG_ROUND_INDEX: r_round_index <= i_cfg_data[ROUND_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (in_fire) n_state = i_in.round_start ? S_ROOT : S_TWO;
            S_ROOT:    if (mm_done) n_state = (sq_limit == '0) ? S_COSET : S_SQUARE;
            S_SQUARE:  if (mm_done && r_sq_cnt == ROUND_BITS'(1)) n_state = S_COSET;
            S_COSET:   if (mm_done) n_state = S_TWO;
            S_TWO:     if (mm_done) n_state = S_RED_B;
            S_RED_B:   if (mm_done) n_state = S_EVEN;
            S_EVEN:    if (mm_done) n_state = S_DIFF;
            S_DIFF:    if (mm_done) n_state = S_RED_DOM;
            S_RED_DOM: if (mm_done) n_state = S_ODD;
            S_ODD:     if (mm_done) n_state = S_CHAL;
            S_CHAL:    if (mm_done) n_state = S_STEP;
            S_STEP:    if (mm_done) n_state = S_OUT;
            S_OUT:     if (!r_out_valid || o_out.ready) n_state = S_IDLE;
        endcase
    end

    // Multiplier operands per step; a multiplier of one reduces x mod q
    always_comb begin
        mm_req.start = (r_state != S_IDLE) && (r_state != S_OUT) && !r_issued;
        mm_req.x     = '0;
        mm_req.m     = VALUE_BITS'(1);
        unique case (r_state)
            S_IDLE, S_OUT: begin
                mm_req.x = '0;
            end
            S_ROOT:    mm_req.x = {1'b0, r_inv_root};
            S_SQUARE: begin
                mm_req.x = {1'b0, r_stride};
                mm_req.m = r_stride;
            end
            S_COSET:   mm_req.x = {1'b0, r_inv_coset};
            S_TWO:     mm_req.x = {1'b0, r_inv_two};
            S_RED_B:   mm_req.x = {1'b0, r_b};
            S_EVEN: begin
                mm_req.x = {1'b0, r_a} + {1'b0, r_b};
                mm_req.m = r_half;
            end
            S_DIFF: begin
                mm_req.x = {1'b0, r_a} + {1'b0, q} - {1'b0, r_tmp};
                mm_req.m = r_half;
            end
            S_RED_DOM: mm_req.x = {1'b0, r_dom};
            S_ODD: begin
                mm_req.x = {1'b0, r_tmp};
                mm_req.m = r_dom;
            end
            S_CHAL: begin
                mm_req.x = {1'b0, r_challenge};
                mm_req.m = r_tmp;
            end
            S_STEP: begin
                mm_req.x = {1'b0, r_stride};
                mm_req.m = r_dom;
            end
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign load_out   = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    // Final sum even + alpha*odd, one conditional subtract
    always_comb begin
        out_sum = {1'b0, r_even} + {1'b0, r_tmp};
        if (out_sum >= {1'b0, q}) begin
            n_folded = VALUE_BITS'(out_sum - {1'b0, q});
        end else begin
            n_folded = VALUE_BITS'(out_sum);
        end
    end

    fri_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mm_req),
        .i_modulus (q),
        .o_done    (mm_done),
        .o_result  (mm_res)
    );

    // Advance sequencer, track the issued pass and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_sq_cnt    <= '0;
            r_out_valid <= 1'b0;
            r_stride    <= '0;
            r_dom       <= '0;
        end else begin
            r_state <= n_state;
            if (mm_done) begin
                r_issued <= 1'b0;
            end else if (mm_req.start) begin
                r_issued <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (mm_done) begin
                unique case (r_state)
                    S_ROOT: begin
                        r_stride <= mm_res;
                        r_sq_cnt <= sq_limit;
                    end
                    S_SQUARE: begin
                        r_stride <= mm_res;
                        r_sq_cnt <= r_sq_cnt - ROUND_BITS'(1);
                    end
                    S_COSET, S_RED_DOM, S_STEP: r_dom <= mm_res;
                    default: ;
                endcase
            end
        end
    end

    // Hold operands and intermediate products
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a <= i_in.value_first;
            r_b <= i_in.value_second;
        end
        if (mm_done) begin
            unique case (r_state)
                S_TWO:                          r_half <= mm_res;
                S_EVEN:                         r_even <= mm_res;
                S_RED_B, S_DIFF, S_ODD, S_CHAL: r_tmp  <= mm_res;
                default: ;
            endcase
        end
        if (load_out) begin
            r_folded <= n_folded;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.folded = r_folded;

endmodule
`default_nettype wire

// ----- design/fri_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "fri_fold_round_assert.svh"
module fri_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            i_in_ready,
    input wire logic                            i_out_valid,
    input wire logic                            i_out_ready,
    input wire logic [fri_pkg::VALUE_BITS-1:0]  i_folded
);
    import fri_pkg::*;

    // One item at a time: ready drops once a transaction is taken
    `FRI_ASSERT(a_ready_drops, (i_in_valid && i_in_ready) |=> !i_in_ready, "ready after accept")

    // Reset empties the output register
    `FRI_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // Hold a stalled result and its value
    `FRI_ASSERT(a_valid_holds, (i_out_valid && !i_out_ready) |=> i_out_valid, "result dropped")
    `FRI_ASSERT(a_folded_holds, (i_out_valid && !i_out_ready) |=> $stable(i_folded), "result changed")

endmodule

bind fri_fold_round fri_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_folded    (o_out.folded)
);
`default_nettype wire

// ----- test/fri_fold_round_checker.sv -----
`timescale 1ns / 1ps
module fri_fold_round_checker
    import fri_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [VALUE_BITS-1:0]   i_cfg_data,
    fri_in_if                       i_in_ch,
    fri_out_if                      i_out_ch,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked
);

    localparam int REPORT_LIMIT = 10;

    typedef logic [63:0] t_wide;

    typedef struct {
        logic [VALUE_BITS-1:0] folded;
        int                    pair_no;
    } t_fold_expect;

    // Shadow copy of the configuration registers
    logic [VALUE_BITS-1:0] modulus_r;
    logic [VALUE_BITS-1:0] inv_two_r;
    logic [VALUE_BITS-1:0] inv_coset_r;
    logic [VALUE_BITS-1:0] inv_root_r;
    logic [VALUE_BITS-1:0] challenge_r;
    logic [ROUND_BITS-1:0] round_r;

    // Shadow copy of the domain point and its per-pair stride
    t_wide domain_inv;
    t_wide stride;

    t_fold_expect expected_folds[$];
    t_fold_expect head;
    int           pairs_seen;
    int           fail_count;
    int           checked;

    function automatic t_wide mul_mod(t_wide x, t_wide y, t_wide q);
        return ((x % q) * (y % q)) % q;
    endfunction

    // Fold one pair and advance the domain point, as the block does
    function automatic logic [VALUE_BITS-1:0] fold_pair(logic [VALUE_BITS-1:0] f_pos,
                                                        logic [VALUE_BITS-1:0] f_neg,
                                                        logic                  first);
        t_wide                 q;
        t_wide                 a;
        t_wide                 b;
        t_wide                 even_part;
        t_wide                 odd_part;
        t_wide                 sum;
        logic [ROUND_BITS-1:0] squarings;
        q = (modulus_r < MIN_MODULUS) ? t_wide'(MIN_MODULUS) : t_wide'(modulus_r);
        a = t_wide'(f_pos) % q;
        b = t_wide'(f_neg) % q;
        // Reload the domain point and rebuild the stride at a round start
        if (first) begin
            squarings = (round_r > LAST_ROUND) ? LAST_ROUND : round_r;
            stride    = t_wide'(inv_root_r) % q;
            for (int k = 0; k < int'(squarings); k++)
                stride = mul_mod(stride, stride, q);
            domain_inv = t_wide'(inv_coset_r) % q;
        end
        even_part = mul_mod((a + b) % q, t_wide'(inv_two_r), q);
        odd_part  = mul_mod(mul_mod((a + q - b) % q, t_wide'(inv_two_r), q), domain_inv, q);
        sum       = even_part + mul_mod(t_wide'(challenge_r), odd_part, q);
        if (sum >= q)
            sum = sum - q;
        domain_inv = mul_mod(domain_inv, stride, q);
        return sum[VALUE_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            modulus_r   = VALUE_BITS'(3);
            inv_two_r   = VALUE_BITS'(2);
            inv_coset_r = VALUE_BITS'(1);
            inv_root_r  = VALUE_BITS'(1);
            challenge_r = '0;
            round_r     = '0;
            domain_inv  = '0;
            stride      = '0;
            expected_folds.delete();
        end else begin
            // Track register writes; spare indexes fall through
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODULUS:     modulus_r   = i_cfg_data;
                    CFG_INV_TWO:     inv_two_r   = i_cfg_data;
                    CFG_INV_COSET:   inv_coset_r = i_cfg_data;
                    CFG_INV_ROOT:    inv_root_r  = i_cfg_data;
                    CFG_CHALLENGE:   challenge_r = i_cfg_data;
                    CFG_ROUND_INDEX: round_r     = i_cfg_data[ROUND_BITS-1:0];
                    default: ;
                endcase
            end

            // Compare a result transaction with the oldest expectation
            if (i_out_ch.valid && i_out_ch.ready) begin
                checked++;
                if (expected_folds.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("[%0t] unexpected result folded=0x%08h, nothing pending",
                                 $time, i_out_ch.folded);
                end else begin
                    head = expected_folds.pop_front();
                    if (i_out_ch.folded !== head.folded) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("[%0t] pair %0d: folded expected 0x%08h, got 0x%08h",
                                     $time, head.pair_no, head.folded, i_out_ch.folded);
                    end
                end
            end

            // Predict the result of an input transaction
            if (i_in_ch.valid && i_in_ch.ready) begin
                head.folded  = fold_pair(i_in_ch.value_first, i_in_ch.value_second,
                                         i_in_ch.round_start);
                head.pair_no = pairs_seen;
                expected_folds.push_back(head);
                pairs_seen++;
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_folds.size();
        o_checked    <= checked;
    end

endmodule

// ----- test/fri_fold_round_tb.sv -----
`timescale 1ns / 1ps
module fri_fold_round_tb;
    import fri_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int ITEM_TOTAL      = 1050;
    localparam int QUIET_TAIL      = 150;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int SETTLE_CYCLES   = 600;
    localparam int LIMIT_NS        = 40_000_000;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 3'd7;

    localparam logic [VALUE_BITS-1:0] ALL_ONES  = '1;
    localparam logic [VALUE_BITS-1:0] PRIME_HI  = 30'd1073741789;
    localparam logic [VALUE_BITS-1:0] PRIME_NTT = 30'd998244353;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [VALUE_BITS-1:0]   cfg_data;

    fri_in_if  in_ch();
    fri_out_if out_ch();

    int fail_count;
    int pending;
    int checked;

    // Stimulus bookkeeping and idling controls
    logic [VALUE_BITS-1:0] cur_modulus;
    bit                    tx_gaps;
    bit                    rx_stalls;
    int                    rx_hold_cycles;
    int                    pairs_sent;
    int                    round_starts;
    int                    unreduced_pairs;
    int                    phases;

    fri_fold_round DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    fri_fold_round_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // Hard stop
    initial begin
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [VALUE_BITS-1:0] active_q();
        return (cur_modulus < MIN_MODULUS) ? MIN_MODULUS : cur_modulus;
    endfunction

    // Half of q plus one: the inverse of two for an odd modulus
    function automatic logic [VALUE_BITS-1:0] half_inverse(logic [VALUE_BITS-1:0] q);
        return (q >> 1) + 1'b1;
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [VALUE_BITS-1:0] q;
        q = active_q();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return q - 1'b1;
            2, 3:    return VALUE_BITS'($urandom());
            default: return VALUE_BITS'($urandom_range(0, q - 1));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [VALUE_BITS-1:0]   data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_MODULUS)
            cur_modulus = data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Write the registers selected by the mask, in index order
    task automatic program_field(input logic [5:0]            mask,
                                 input logic [VALUE_BITS-1:0] q,
                                 input logic [VALUE_BITS-1:0] two,
                                 input logic [VALUE_BITS-1:0] coset,
                                 input logic [VALUE_BITS-1:0] root,
                                 input logic [VALUE_BITS-1:0] alpha,
                                 input logic [ROUND_BITS-1:0] rnd);
        if (mask[CFG_MODULUS])     write_reg(CFG_MODULUS, q);
        if (mask[CFG_INV_TWO])     write_reg(CFG_INV_TWO, two);
        if (mask[CFG_INV_COSET])   write_reg(CFG_INV_COSET, coset);
        if (mask[CFG_INV_ROOT])    write_reg(CFG_INV_ROOT, root);
        if (mask[CFG_CHALLENGE])   write_reg(CFG_CHALLENGE, alpha);
        if (mask[CFG_ROUND_INDEX]) write_reg(CFG_ROUND_INDEX, VALUE_BITS'(rnd));
    endtask

    // Offer one pair, optionally after an idle burst, and hold until taken
    task automatic send_pair(input logic [VALUE_BITS-1:0] f_pos,
                             input logic [VALUE_BITS-1:0] f_neg,
                             input logic                  first);
        if (tx_gaps && $urandom_range(0, 2) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.value_first  <= f_pos;
        in_ch.value_second <= f_neg;
        in_ch.round_start  <= first;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        pairs_sent++;
        if (first)
            round_starts++;
        if (f_pos >= active_q() || f_neg >= active_q())
            unreduced_pairs++;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Result receiver: random stall bursts plus a single long hold-off
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_cycles != 0) begin
                out_ch.ready <= 1'b0;
                repeat (rx_hold_cycles - 1) @(negedge clk);
                rx_hold_cycles = 0;
            end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [5:0]            mask;
        logic [VALUE_BITS-1:0] q;
        logic [VALUE_BITS-1:0] two;
        int                    phase_len;
        bit                    first_random;
        logic                  first;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.value_first  = '0;
        in_ch.value_second = '0;
        in_ch.round_start  = 1'b0;
        cur_modulus        = VALUE_BITS'(3);
        tx_gaps            = 1'b1;
        rx_stalls          = 1'b1;
        rx_hold_cycles     = 0;
        pairs_sent         = 0;
        round_starts       = 0;
        unreduced_pairs    = 0;
        phases             = 0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Before any round start the domain point is still zero
        send_pair(ALL_ONES, '0, 1'b0);
        send_pair('0, ALL_ONES, 1'b0);
        wait_drained();

        // Large prime field, round zero, operand extremes
        program_field('1, PRIME_HI, half_inverse(PRIME_HI), VALUE_BITS'($urandom()),
                      VALUE_BITS'($urandom()), PRIME_HI - 1'b1, '0);
        send_pair('0, '0, 1'b1);
        send_pair(PRIME_HI - 1'b1, '0, 1'b0);
        send_pair('0, PRIME_HI - 1'b1, 1'b0);
        send_pair(ALL_ONES, ALL_ONES, 1'b0);
        send_pair(PRIME_HI - 1'b1, PRIME_HI - 1'b1, 1'b0);
        send_pair(pick_value(), pick_value(), 1'b0);
        wait_drained();

        // Round index past the last round saturates the stride
        write_reg(CFG_ROUND_INDEX, VALUE_BITS'(ROUND_BITS'('1)));
        send_pair(pick_value(), pick_value(), 1'b1);
        send_pair(pick_value(), pick_value(), 1'b0);
        send_pair(pick_value(), pick_value(), 1'b0);
        wait_drained();

        // Mid-round changes: domain registers wait for the next round start
        program_field(6'b111100, '0, '0, VALUE_BITS'($urandom()), VALUE_BITS'($urandom()),
                      VALUE_BITS'($urandom()), ROUND_BITS'(3));
        send_pair(pick_value(), pick_value(), 1'b0);
        send_pair(pick_value(), pick_value(), 1'b0);
        send_pair(pick_value(), pick_value(), 1'b1);
        wait_drained();

        // Spare indexes must leave every register alone
        write_reg(CFG_SPARE_A, VALUE_BITS'($urandom()));
        write_reg(CFG_SPARE_B, ALL_ONES);
        send_pair(pick_value(), pick_value(), 1'b0);
        wait_drained();

        // Moduli below three act as three
        write_reg(CFG_MODULUS, VALUE_BITS'(0));
        send_pair(ALL_ONES, ALL_ONES, 1'b1);
        send_pair(pick_value(), pick_value(), 1'b0);
        wait_drained();
        write_reg(CFG_MODULUS, VALUE_BITS'(1));
        send_pair(pick_value(), pick_value(), 1'b1);
        wait_drained();
        write_reg(CFG_MODULUS, VALUE_BITS'(2));
        send_pair(pick_value(), pick_value(), 1'b0);
        wait_drained();

        // Widest modulus, last round, all-ones challenge
        program_field('1, ALL_ONES, half_inverse(ALL_ONES), ALL_ONES, ALL_ONES,
                      ALL_ONES, LAST_ROUND);
        send_pair(ALL_ONES - 1'b1, '0, 1'b1);
        send_pair(pick_value(), pick_value(), 1'b0);
        phases = 7;

        // Random phases: new settings, then rounds of pairs
        first_random = 1'b1;
        while (pairs_sent < ITEM_TOTAL) begin
            if (pairs_sent >= ITEM_TOTAL - QUIET_TAIL) begin
                tx_gaps   = 1'b0;
                rx_stalls = 1'b0;
            end
            wait_drained();
            case ($urandom_range(0, 9))
                0:       q = VALUE_BITS'($urandom_range(0, 2));
                1:       q = ALL_ONES;
                2:       q = VALUE_BITS'($urandom_range(3, 255));
                3, 4:    q = PRIME_HI;
                5, 6:    q = PRIME_NTT;
                default: q = VALUE_BITS'($urandom());
            endcase
            two = ($urandom_range(0, 4) == 0) ? VALUE_BITS'($urandom()) : half_inverse(q);
            for (int k = 0; k < 6; k++)
                mask[k] = ($urandom_range(0, 3) != 0);
            program_field(mask, q, two, VALUE_BITS'($urandom()), VALUE_BITS'($urandom()),
                          VALUE_BITS'($urandom()), ROUND_BITS'($urandom_range(0, 7)));
            // Hold results back once so the block fills and stalls its input
            if (first_random) begin
                rx_hold_cycles = HOLD_OFF_CYCLES;
                first_random   = 1'b0;
            end
            phase_len = $urandom_range(10, 60);
            for (int k = 0; k < phase_len; k++) begin
                first = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 11) == 0);
                send_pair(pick_value(), pick_value(), first);
            end
            phases++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Folded %0d pairs over %0d setting phases: %0d round starts, %0d unreduced.",
                 pairs_sent, phases, round_starts, unreduced_pairs);
        $display("Compared %0d results, %0d failures, %0d still pending.",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
